>>> hdl/table_with_global_fill_and_sum_unit_defines.svh
// Assertion macros for the table with global fill and running sum.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TABLE_WITH_GLOBAL_FILL_AND_SUM_UNIT_DEFINES_SVH
`define TABLE_WITH_GLOBAL_FILL_AND_SUM_UNIT_DEFINES_SVH

// same-cycle implication
`define TWGFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("twgfs: same-cycle check failed");

// next-cycle implication
`define TWGFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("twgfs: next-cycle check failed");

// at most one of a group of strobes
`define TWGFS_ASSERT_ONEHOT0(lbl, vec) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(vec)) \
        else $error("twgfs: strobe overlap");

`endif

>>> hdl/twgfs_pkg.sv
// Package for the table with global fill and running sum.
// Field widths, defaults, request codes, FSM states and control structs.
`timescale 1ns / 1ps
`default_nettype none

package twgfs_pkg;

    localparam int TYPE_W          = 1;
    localparam int INDEX_W         = 10;
    localparam int FIELD_VALUE_W   = 30;
    localparam int TOTAL_W         = 40;
    localparam int COUNT_W         = 11;
    localparam int COUNT_RESET     = 1024;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 30;
    localparam int EPOCH_W         = 8;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

    typedef enum logic [TYPE_W-1:0] {
        REQ_POINT = 1'b0,
        REQ_FILL  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic commit;
        logic sweep;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic wrap;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/twgfs_req_if.sv
// Request channel: valid/ready handshake with the request payload.
// Depends on twgfs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface twgfs_req_if
    import twgfs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic [INDEX_W-1:0]       entry_index;
    logic [FIELD_VALUE_W-1:0] new_value;

    modport source (output valid, output req_type, output entry_index, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input entry_index, input new_value,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/twgfs_rsp_if.sv
// Result channel: valid/ready handshake with the total and error flag.
// Depends on twgfs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface twgfs_rsp_if
    import twgfs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total;
    logic               index_error;

    modport source (output valid, output total, output index_error, input ready);
    modport sink   (input valid, input total, input index_error, output ready);
endinterface

`default_nettype wire

>>> hdl/twgfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module twgfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/twgfs_ctrl.sv
// Controller FSM: clearing pass, accept, execute, commit.
// Depends on twgfs_pkg for states and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module twgfs_ctrl
    import twgfs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output      logic o_req_ready,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.wrap ? ST_SWEEP : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
            end
            ST_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/twgfs_dpath.sv
// Datapath: tagged entry RAM, fill value, epoch, running total, multiplier,
// result register. Depends on twgfs_pkg and twgfs_ram.
`timescale 1ns / 1ps
`default_nettype none

module twgfs_dpath
    import twgfs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output      t_sts                     o_sts,
    input  wire logic                     i_cfg_we,
    input  wire logic [COUNT_W-1:0]       i_cfg_wdata,
    input  wire logic [TYPE_W-1:0]        i_req_type,
    input  wire logic [INDEX_W-1:0]       i_entry_index,
    input  wire logic [FIELD_VALUE_W-1:0] i_new_value,
    output      logic                     o_rsp_valid,
    input  wire logic                     i_rsp_ready,
    output      logic [TOTAL_W-1:0]       o_total,
    output      logic                     o_index_error
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int ACT_W  = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int MEM_W  = EPOCH_W + VALUE_WIDTH;
    localparam int PROD_W = ACT_W + VALUE_WIDTH;
    localparam logic [ACT_W-1:0]  DEPTH_C   = ACT_W'(TABLE_DEPTH);
    localparam logic [ACT_W-1:0]  ACT_RESET = (COUNT_RESET > TABLE_DEPTH) ?
                                              ACT_W'(TABLE_DEPTH) : ACT_W'(COUNT_RESET);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TABLE_DEPTH - 1);

    logic [ACT_W-1:0]       r_act;
    logic [ACT_W-1:0]       w_cfg_ext;
    logic [VALUE_WIDTH-1:0] r_fill;
    logic [EPOCH_W-1:0]     r_epoch;
    logic [TOTAL_W-1:0]     r_total;
    logic [ADDR_W-1:0]      r_sweep_addr;
    logic                   r_out_valid;

    logic                   r_kind;
    logic [INDEX_W-1:0]     r_idx;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_err;
    logic [TOTAL_W-1:0]     r_calc;

    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [MEM_W-1:0]       w_wdata;
    logic [MEM_W-1:0]       w_rdata;
    logic [EPOCH_W-1:0]     w_tag;
    logic [VALUE_WIDTH-1:0] w_old;
    logic [PROD_W-1:0]      w_prod;
    logic                   w_is_fill;

    assign w_cfg_ext = ACT_W'(i_cfg_wdata);
    assign w_is_fill = (r_kind == REQ_FILL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACT_RESET;
        end else if (i_cfg_we) begin
            r_act <= (w_cfg_ext > DEPTH_C) ? DEPTH_C : w_cfg_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_addr <= (r_sweep_addr == ADDR_LAST) ? '0 : r_sweep_addr + ADDR_W'(1);
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_req_type;
            r_idx  <= i_entry_index;
            r_val  <= VALUE_WIDTH'(i_new_value);
            r_err  <= (i_req_type == REQ_POINT) && (ACT_W'(i_entry_index) >= r_act);
        end
    end

    // stale entry (tag differs from current epoch) reads as the fill value
    assign w_tag  = w_rdata[MEM_W-1 -: EPOCH_W];
    assign w_old  = (w_tag == r_epoch) ? w_rdata[VALUE_WIDTH-1:0] : r_fill;
    assign w_prod = PROD_W'(r_act) * PROD_W'(r_val);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_is_fill) begin
                r_calc <= TOTAL_W'(w_prod);
            end else if (r_err) begin
                r_calc <= r_total;
            end else begin
                r_calc <= r_total + TOTAL_W'(r_val) - TOTAL_W'(w_old);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_fill  <= '0;
            r_epoch <= EPOCH_FIRST;
        end else if (i_cmd.commit) begin
            r_total <= r_calc;
            if (w_is_fill) begin
                r_fill  <= r_val;
                r_epoch <= (r_epoch == EPOCH_MAX) ? EPOCH_FIRST : r_epoch + EPOCH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_total       <= r_calc;
            o_index_error <= r_err;
        end
    end

    assign o_rsp_valid = r_out_valid;

    assign w_we    = i_cmd.sweep || (i_cmd.commit && !w_is_fill && !r_err);
    assign w_waddr = i_cmd.sweep ? r_sweep_addr : ADDR_W'(r_idx);
    assign w_wdata = i_cmd.sweep ? {EPOCH_NONE, VALUE_WIDTH'(0)} : {r_epoch, r_val};

    twgfs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (ADDR_W'(i_entry_index)),
        .o_rdata (w_rdata)
    );

    assign o_sts.sweep_last = i_cmd.sweep && (r_sweep_addr == ADDR_LAST);
    assign o_sts.wrap       = w_is_fill && (r_epoch == EPOCH_MAX);
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

endmodule

`default_nettype wire

>>> hdl/table_with_global_fill_and_sum_unit.sv
// Table of values with lazy global fill and a running total: top level.
// Depends on twgfs_pkg, twgfs_req_if, twgfs_rsp_if, twgfs_ctrl, twgfs_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Each request (point set or fill) goes through accept with the RAM read
// issued, execute (old-entry resolve and add, or the count-times-value
// multiply) into a register, then commit to the total and the result
// register once it is free. The next request is taken only after commit, in
// the cycle after it or after the clearing pass on an epoch wrap. Entries
// carry an 8-bit fill epoch tag, so a fill is O(1). A clearing pass over the
// table runs after reset and again after every 255th fill (epoch wrap); no
// request is taken during it, configuration writes are. A finished result
// waits in its output register while the next request is taken.
module table_with_global_fill_and_sum_unit
    import twgfs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    twgfs_req_if.sink               i_req,
    twgfs_rsp_if.source             o_rsp,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    twgfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    twgfs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req.req_type),
        .i_entry_index (i_req.entry_index),
        .i_new_value   (i_req.new_value),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_total       (o_rsp.total),
        .o_index_error (o_rsp.index_error)
    );

`include "table_with_global_fill_and_sum_unit_defines.svh"

    `TWGFS_ASSERT_IMP(a_no_accept_in_sweep, w_cmd.sweep, !i_req.ready)
    `TWGFS_ASSERT_NXT(a_accept_then_exec, i_req.valid && i_req.ready, w_cmd.exec)
    `TWGFS_ASSERT_NXT(a_commit_loads_result, w_cmd.commit, o_rsp.valid)
    `TWGFS_ASSERT_ONEHOT0(a_cmd_exclusive,
        {w_cmd.capture, w_cmd.exec, w_cmd.commit, w_cmd.sweep})

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for table_with_global_fill_and_sum_unit: point sets and fills, checked against
// an in-bench model of the table and its running total. Depends on twgfs_pkg and the
// request and result interfaces.
`timescale 1ns / 1ps

module tb;
    import twgfs_pkg::*;

    localparam int TIMEOUT_NS  = 3_000_000;
    localparam int RANDOM_REQS = 500;
    localparam int HOLD_CYCLES = 80;
    localparam logic [FIELD_VALUE_W-1:0] VAL_MAX = '1;
    localparam logic [INDEX_W-1:0]       IDX_MAX = '1;

    typedef struct packed {
        t_req_type                kind;
        logic [INDEX_W-1:0]       idx;
        logic [FIELD_VALUE_W-1:0] val;
    } t_req_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               index_error;
    } t_sum_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    twgfs_req_if rq ();
    twgfs_rsp_if rs ();

    table_with_global_fill_and_sum_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (rq),
        .o_rsp      (rs),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // table model
    logic [FIELD_VALUE_W-1:0] slot_value [DEF_TABLE_DEPTH];
    bit                       slot_written [DEF_TABLE_DEPTH];
    logic [FIELD_VALUE_W-1:0] fill_level = '0;
    logic [TOTAL_W-1:0]       sum_total = '0;
    logic [COUNT_W-1:0]       count_reg = COUNT_W'(COUNT_RESET);

    t_req_item   request_backlog [$];
    t_sum_result awaited_sums [$];
    t_req_item   next_req;
    bit          offer_live = 0;
    bit          no_idle = 0;
    bit          hold_req = 0;
    int          hold_left = 0;
    int          mismatches = 0;

    function automatic t_sum_result apply_request(t_req_item r);
        t_sum_result              res;
        logic [COUNT_W-1:0]       active;
        logic [63:0]              prod;
        logic [FIELD_VALUE_W-1:0] prior;
        active = (count_reg > DEF_TABLE_DEPTH) ? COUNT_W'(DEF_TABLE_DEPTH) : count_reg;
        res.index_error = 1'b0;
        if (r.kind == REQ_FILL) begin
            fill_level = r.val;
            foreach (slot_written[k]) slot_written[k] = 0;
            prod = 64'(active) * 64'(r.val);
            sum_total = prod[TOTAL_W-1:0];
        end else if (COUNT_W'(r.idx) < active) begin
            prior = slot_written[r.idx] ? slot_value[r.idx] : fill_level;
            sum_total = sum_total + TOTAL_W'(r.val) - TOTAL_W'(prior);
            slot_value[r.idx] = r.val;
            slot_written[r.idx] = 1;
        end else begin
            res.index_error = 1'b1;
        end
        res.total = sum_total;
        return res;
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic push_req(t_req_type k, logic [INDEX_W-1:0] idx,
                            logic [FIELD_VALUE_W-1:0] val);
        t_req_item r;
        r.kind = k;
        r.idx  = idx;
        r.val  = val;
        request_backlog = {request_backlog, r};
    endtask

    task automatic wait_drained();
        while (request_backlog.size() != 0 || offer_live || awaited_sums.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // request driver
    always @(negedge i_clk) begin
        if (!offer_live) begin
            if (request_backlog.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
                next_req = request_backlog.pop_front();
                rq.valid       <= 1'b1;
                rq.req_type    <= next_req.kind;
                rq.entry_index <= next_req.idx;
                rq.new_value   <= next_req.val;
                offer_live = 1;
            end else begin
                rq.valid       <= 1'b0;
                rq.req_type    <= TYPE_W'($urandom);
                rq.entry_index <= INDEX_W'($urandom);
                rq.new_value   <= FIELD_VALUE_W'($urandom);
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rs.ready <= 1'b0;
        end else begin
            rs.ready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    // monitor: predicts on accepted requests, checks accepted results
    always @(posedge i_clk) begin
        t_req_item   acc;
        t_sum_result want;
        if (i_rst_n && i_cfg_we) count_reg = i_cfg_wdata;
        if (i_rst_n && rq.valid && rq.ready) begin
            acc.kind = t_req_type'(rq.req_type);
            acc.idx  = rq.entry_index;
            acc.val  = rq.new_value;
            awaited_sums = {awaited_sums, apply_request(acc)};
            offer_live = 0;
        end
        if (i_rst_n && rs.valid && rs.ready) begin
            if (awaited_sums.size() == 0) begin
                flag_mismatch($sformatf("unexpected result total=%0d", rs.total));
            end else begin
                want = awaited_sums.pop_front();
                if (rs.total !== want.total)
                    flag_mismatch($sformatf("total got %0d want %0d", rs.total, want.total));
                if (rs.index_error !== want.index_error)
                    flag_mismatch($sformatf("index_error got %0b want %0b",
                                            rs.index_error, want.index_error));
            end
        end
    end

    initial begin
        int        cnt;
        int        eff;
        int        len;
        int        fill_pct;
        int        random_sent;
        int        phase;
        int        roll;
        t_req_item it;

        rq.valid       = 1'b0;
        rq.req_type    = REQ_POINT;
        rq.entry_index = '0;
        rq.new_value   = '0;
        rs.ready       = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_rst_n        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset count, extremes, stale reads after fill
        push_req(REQ_POINT, '0, '0);
        push_req(REQ_POINT, IDX_MAX, VAL_MAX);
        push_req(REQ_POINT, '0, VAL_MAX);
        push_req(REQ_POINT, '0, 30'h2AAA_AAAA);
        push_req(REQ_POINT, IDX_MAX, 30'h1555_5555);
        push_req(REQ_FILL, 10'h155, VAL_MAX);
        push_req(REQ_POINT, 10'd512, '0);
        push_req(REQ_POINT, 10'd512, 30'd1);
        push_req(REQ_FILL, 10'h2AA, '0);
        push_req(REQ_POINT, 10'd3, 30'd5);
        wait_drained();

        // count zero: every point set flagged, fill gives zero
        write_count('0);
        push_req(REQ_POINT, '0, 30'd7);
        push_req(REQ_FILL, '0, 30'd9);
        push_req(REQ_POINT, IDX_MAX, 30'd7);
        wait_drained();

        // count above depth is clamped
        write_count('1);
        push_req(REQ_FILL, '0, 30'd1);
        push_req(REQ_POINT, IDX_MAX, 30'd2);
        wait_drained();

        write_count(COUNT_W'(1));
        push_req(REQ_FILL, '0, 30'd100);
        push_req(REQ_POINT, 10'd1, 30'd3);
        push_req(REQ_POINT, '0, 30'd50);
        wait_drained();

        // count change without recompute, total wraps down then up
        write_count(COUNT_W'(1024));
        push_req(REQ_POINT, 10'd5, '0);
        push_req(REQ_POINT, 10'd6, VAL_MAX);
        push_req(REQ_POINT, 10'd5, 30'd100);
        wait_drained();

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_REQS) begin
            wait_drained();
            case ($urandom_range(9))
                0: cnt = 0;
                1: cnt = 1;
                2: cnt = 2047;
                3: cnt = 1024;
                4: cnt = 1023;
                5: cnt = 1025;
                6: cnt = $urandom_range(2047, 1);
                default: cnt = $urandom_range(16, 1);
            endcase
            write_count(COUNT_W'(cnt));
            eff = (cnt > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : cnt;
            no_idle = (phase == 4);
            len = (phase == 2 || phase == 4) ? 100 : $urandom_range(60, 10);
            case ($urandom_range(2))
                0: fill_pct = 30;
                1: fill_pct = 60;
                default: fill_pct = 90;
            endcase
            for (int i = 0; i < len; i++) begin
                it.kind = ($urandom_range(99) < fill_pct) ? REQ_FILL : REQ_POINT;
                roll = $urandom_range(99);
                if (eff == 0 || roll >= 95)
                    it.idx = INDEX_W'($urandom);
                else if (roll >= 85 && eff < DEF_TABLE_DEPTH)
                    it.idx = INDEX_W'($urandom_range(DEF_TABLE_DEPTH - 1, eff));
                else
                    it.idx = INDEX_W'($urandom_range(eff - 1, 0));
                roll = $urandom_range(99);
                if (roll < 10)
                    it.val = '0;
                else if (roll < 20)
                    it.val = VAL_MAX;
                else
                    it.val = FIELD_VALUE_W'($urandom);
                request_backlog = {request_backlog, it};
                random_sent++;
            end
            // long receiver stall while the sender keeps offering
            if (phase == 2) begin
                @(posedge i_clk);
                hold_req = 1;
            end
            phase++;
        end

        wait_drained();
        no_idle = 0;
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
